/* design/dwd_pkg.sv */
// ----------------------------------------------------------------------------
// dwd_pkg
// Shared widths, calendar tables, reciprocal constants and the pipeline
// load-enable type for the date weekday and day difference unit.
// ----------------------------------------------------------------------------
package dwd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIFF_W  = 23;
    localparam int WDAY_W  = 3;

    // biased year: year + 400, minus one for January and February
    localparam int YB_W    = YEAR_W + 1;
    localparam int DNUM_W  = 23;            // day number (plus a common constant)
    localparam int LEAP_W  = YB_W - 2;      // leap year count, at most yb / 4
    localparam int WSUM_W  = 15;            // weekday sum before mod 7
    localparam int DBM_W   = 9;             // days before month plus day
    localparam int SAK_W   = 6;             // weekday month offset plus day
    localparam int PROD_W  = 26;            // divide-by-25 products
    localparam int WPROD_W = 30;            // divide-by-7 products

    localparam logic [YB_W-1:0]   YEAR_BIAS  = YB_W'(400);
    localparam logic [DNUM_W-1:0] DAYS_YEAR  = DNUM_W'(365);
    // floor(x / 25) = (x * 5243) >> 17 for x below 43690
    localparam logic [12:0]       RECIP_25   = 13'd5243;
    // floor(x / 7) = (x * 18725) >> 17 for x below 43690
    localparam logic [14:0]       RECIP_7    = 15'd18725;
    localparam int                RECIP_SH   = 17;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_ld;

    // month 0 reads as January, 13 to 15 as December
    function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        r = m;
        if (m < MONTH_W'(1)) begin
            r = MONTH_W'(1);
        end else if (m > MONTH_W'(12)) begin
            r = MONTH_W'(12);
        end
        return r;
    endfunction

    // cumulative days of the earlier months of a common year
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] r;
        case (m)
            4'd1:    r = DBM_W'(0);
            4'd2:    r = DBM_W'(31);
            4'd3:    r = DBM_W'(59);
            4'd4:    r = DBM_W'(90);
            4'd5:    r = DBM_W'(120);
            4'd6:    r = DBM_W'(151);
            4'd7:    r = DBM_W'(181);
            4'd8:    r = DBM_W'(212);
            4'd9:    r = DBM_W'(243);
            4'd10:   r = DBM_W'(273);
            4'd11:   r = DBM_W'(304);
            default: r = DBM_W'(334);
        endcase
        return r;
    endfunction

    // weekday month offsets of the Sakamoto method
    function automatic logic [2:0] sak_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

endpackage

/* design/date_weekday_and_day_difference_unit.sv */
// ----------------------------------------------------------------------------
// date_weekday_and_day_difference_unit
// Day difference, weekdays and order flags for a pair of Gregorian dates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_ready with dates A and B (year, month, day).
//   Output channel: o_valid / i_ready with the day difference B - A
//   (23-bit two's complement, wraps when out of range), weekday of each
//   date (1 Sunday .. 7 Saturday) and the before / after / equal flags.
//   A transfer happens on a rising edge with valid and ready both high.
//   Months 0 and 13..15 read as January and December; days are not
//   checked against the month length.
// Pipeline and throughput:
//   Five register stages; one date pair per cycle is sustained while the
//   receiver keeps i_ready high.
// Reset and stalls:
//   Synchronous active-low reset clears all stage valid bits; payload
//   registers are not reset. Each stage has its own valid bit and loads
//   when it is empty or its successor loads, so a stalled receiver fills
//   the bubbles first and then holds every stage; nothing is dropped or
//   repeated.
// ----------------------------------------------------------------------------
module date_weekday_and_day_difference_unit
    import dwd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [YEAR_W-1:0]           i_year_a,
    input  logic [MONTH_W-1:0]          i_month_a,
    input  logic [DAY_W-1:0]            i_day_a,
    input  logic [YEAR_W-1:0]           i_year_b,
    input  logic [MONTH_W-1:0]          i_month_b,
    input  logic [DAY_W-1:0]            i_day_b,

    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [DIFF_W-1:0]    o_day_difference,
    output logic [WDAY_W-1:0]           o_weekday_a,
    output logic [WDAY_W-1:0]           o_weekday_b,
    output logic                        o_a_before_b,
    output logic                        o_a_after_b,
    output logic                        o_dates_equal
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] w_rdy;
    t_pipe_ld          w_ld;

    logic              n_eq;
    logic              r_eq1;
    logic              r_eq2;
    logic              r_eq3;

    logic [DNUM_W-1:0] w_dnum_a;
    logic [DNUM_W-1:0] w_dnum_b;
    logic [WSUM_W-1:0] w_wsum_a;
    logic [WSUM_W-1:0] w_wsum_b;
    logic [DIFF_W-1:0] w_diff;

    // stage k loads when it is empty or the next stage takes its item
    always_comb begin
        w_rdy[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        n_vld[0] = w_rdy[0] ? i_valid : r_vld[0];
        for (int k = 1; k < STAGES; k++) begin
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
        w_ld.s1 = w_rdy[0];
        w_ld.s2 = w_rdy[1];
        w_ld.s3 = w_rdy[2];
        w_ld.s4 = w_rdy[3];
        w_ld.s5 = w_rdy[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[STAGES-1];

    // equality on the clamped month; carry it alongside the date stages
    assign n_eq = (i_year_a == i_year_b)
               && (clamp_month(i_month_a) == clamp_month(i_month_b))
               && (i_day_a == i_day_b);

    always_ff @(posedge i_clk) begin
        if (w_ld.s1) begin
            r_eq1 <= n_eq;
        end
        if (w_ld.s2) begin
            r_eq2 <= r_eq1;
        end
        if (w_ld.s3) begin
            r_eq3 <= r_eq2;
        end
    end

    dwd_date_unit u_date_a (
        .i_clk   (i_clk),
        .i_ld    (w_ld),
        .i_year  (i_year_a),
        .i_month (i_month_a),
        .i_day   (i_day_a),
        .o_dnum  (w_dnum_a),
        .o_wsum  (w_wsum_a)
    );

    dwd_date_unit u_date_b (
        .i_clk   (i_clk),
        .i_ld    (w_ld),
        .i_year  (i_year_b),
        .i_month (i_month_b),
        .i_day   (i_day_b),
        .o_dnum  (w_dnum_b),
        .o_wsum  (w_wsum_b)
    );

    dwd_result_unit u_result (
        .i_clk    (i_clk),
        .i_ld     (w_ld),
        .i_dnum_a (w_dnum_a),
        .i_dnum_b (w_dnum_b),
        .i_wsum_a (w_wsum_a),
        .i_wsum_b (w_wsum_b),
        .i_eq     (r_eq3),
        .o_diff   (w_diff),
        .o_wday_a (o_weekday_a),
        .o_wday_b (o_weekday_b),
        .o_before (o_a_before_b),
        .o_after  (o_a_after_b),
        .o_eq     (o_dates_equal)
    );

    assign o_day_difference = $signed(w_diff);

    // equal dates give a zero difference and neither order flag
    a_equal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dates_equal |->
            (o_day_difference == '0) && !o_a_before_b && !o_a_after_b)
        else $error("equal dates with nonzero difference or order flag");

    // order flags are exclusive
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_a_before_b && o_a_after_b))
        else $error("before and after both set");

    // weekday codes never zero
    a_wday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_weekday_a != '0) && (o_weekday_b != '0))
        else $error("weekday out of range");

    // equal dates fall on the same weekday
    a_equal_wday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dates_equal |-> (o_weekday_a == o_weekday_b))
        else $error("equal dates with different weekdays");

endmodule

/* design/dwd_date_unit.sv */
// ----------------------------------------------------------------------------
// dwd_date_unit
// Three pipeline stages for one date: biased year and linear terms, the
// divide-by-25 products for the century terms, then day number and weekday sum.
// ----------------------------------------------------------------------------
module dwd_date_unit
    import dwd_pkg::*;
(
    input  logic                i_clk,
    input  t_pipe_ld            i_ld,
    input  logic [YEAR_W-1:0]   i_year,
    input  logic [MONTH_W-1:0]  i_month,
    input  logic [DAY_W-1:0]    i_day,
    output logic [DNUM_W-1:0]   o_dnum,
    output logic [WSUM_W-1:0]   o_wsum
);

    logic [MONTH_W-1:0] w_month;
    logic [YB_W-1:0]    n_yb;
    logic [DNUM_W-1:0]  n_y365;
    logic [DBM_W-1:0]   n_dbm;
    logic [SAK_W-1:0]   n_sak;

    logic [YB_W-1:0]    r1_yb;
    logic [DNUM_W-1:0]  r1_y365;
    logic [DBM_W-1:0]   r1_dbm;
    logic [SAK_W-1:0]   r1_sak;

    logic [PROD_W-1:0]  n_p4;
    logic [PROD_W-1:0]  n_p16;
    logic [YB_W-1:0]    r2_yb;
    logic [DNUM_W-1:0]  r2_y365;
    logic [DBM_W-1:0]   r2_dbm;
    logic [SAK_W-1:0]   r2_sak;
    logic [PROD_W-1:0]  r2_p4;
    logic [PROD_W-1:0]  r2_p16;

    logic [LEAP_W-1:0]  w_q4;
    logic [LEAP_W-1:0]  w_d100;
    logic [LEAP_W-1:0]  w_d400;
    logic [LEAP_W-1:0]  w_leap;
    logic [DNUM_W-1:0]  n_dnum;
    logic [WSUM_W-1:0]  n_wsum;
    logic [DNUM_W-1:0]  r3_dnum;
    logic [WSUM_W-1:0]  r3_wsum;

    // stage 1: clamp month, bias year, linear terms
    always_comb begin
        w_month = clamp_month(i_month);
        n_yb    = YB_W'(i_year) + YEAR_BIAS;
        if (w_month <= MONTH_W'(2)) begin
            n_yb = n_yb - YB_W'(1);
        end
        n_y365  = DNUM_W'(i_year) * DAYS_YEAR;
        n_dbm   = days_before_month(w_month) + DBM_W'(i_day);
        n_sak   = SAK_W'(sak_offset(w_month)) + SAK_W'(i_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s1) begin
            r1_yb   <= n_yb;
            r1_y365 <= n_y365;
            r1_dbm  <= n_dbm;
            r1_sak  <= n_sak;
        end
    end

    // stage 2: reciprocal products for yb / 100 and yb / 400
    assign n_p4  = PROD_W'(r1_yb[YB_W-1:2]) * PROD_W'(RECIP_25);
    assign n_p16 = PROD_W'(r1_yb[YB_W-1:4]) * PROD_W'(RECIP_25);

    always_ff @(posedge i_clk) begin
        if (i_ld.s2) begin
            r2_yb   <= r1_yb;
            r2_y365 <= r1_y365;
            r2_dbm  <= r1_dbm;
            r2_sak  <= r1_sak;
            r2_p4   <= n_p4;
            r2_p16  <= n_p16;
        end
    end

    // stage 3: leap count, day number, weekday sum
    always_comb begin
        w_q4   = r2_yb[YB_W-1:2];
        w_d100 = LEAP_W'(r2_p4 >> RECIP_SH);
        w_d400 = LEAP_W'(r2_p16 >> RECIP_SH);
        w_leap = w_q4 - w_d100 + w_d400;
        n_dnum = r2_y365 + DNUM_W'(r2_dbm) + DNUM_W'(w_leap);
        n_wsum = WSUM_W'(w_leap) + WSUM_W'(r2_yb) + WSUM_W'(r2_sak);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s3) begin
            r3_dnum <= n_dnum;
            r3_wsum <= n_wsum;
        end
    end

    assign o_dnum = r3_dnum;
    assign o_wsum = r3_wsum;

endmodule

/* design/dwd_result_unit.sv */
// ----------------------------------------------------------------------------
// dwd_result_unit
// Two pipeline stages joining both dates: difference and mod-7 products,
// then weekdays and order flags into the output register.
// ----------------------------------------------------------------------------
module dwd_result_unit
    import dwd_pkg::*;
(
    input  logic                i_clk,
    input  t_pipe_ld            i_ld,
    input  logic [DNUM_W-1:0]   i_dnum_a,
    input  logic [DNUM_W-1:0]   i_dnum_b,
    input  logic [WSUM_W-1:0]   i_wsum_a,
    input  logic [WSUM_W-1:0]   i_wsum_b,
    input  logic                i_eq,
    output logic [DIFF_W-1:0]   o_diff,
    output logic [WDAY_W-1:0]   o_wday_a,
    output logic [WDAY_W-1:0]   o_wday_b,
    output logic                o_before,
    output logic                o_after,
    output logic                o_eq
);

    logic signed [DNUM_W:0] n_diff;
    logic signed [DNUM_W:0] r4_diff;
    logic [WPROD_W-1:0]     r4_pa;
    logic [WPROD_W-1:0]     r4_pb;
    logic [WSUM_W-1:0]      r4_wa;
    logic [WSUM_W-1:0]      r4_wb;
    logic                   r4_eq;

    logic [WSUM_W-1:0]      w_qa;
    logic [WSUM_W-1:0]      w_qb;
    logic [WSUM_W-1:0]      w_ra;
    logic [WSUM_W-1:0]      w_rb;

    logic [DIFF_W-1:0]      r5_diff;
    logic [WDAY_W-1:0]      r5_wa;
    logic [WDAY_W-1:0]      r5_wb;
    logic                   r5_before;
    logic                   r5_after;
    logic                   r5_eq;

    // stage 4: signed difference and reciprocal products for mod 7
    assign n_diff = $signed({1'b0, i_dnum_b}) - $signed({1'b0, i_dnum_a});

    always_ff @(posedge i_clk) begin
        if (i_ld.s4) begin
            r4_diff <= n_diff;
            r4_pa   <= WPROD_W'(i_wsum_a) * WPROD_W'(RECIP_7);
            r4_pb   <= WPROD_W'(i_wsum_b) * WPROD_W'(RECIP_7);
            r4_wa   <= i_wsum_a;
            r4_wb   <= i_wsum_b;
            r4_eq   <= i_eq;
        end
    end

    // stage 5: remainder = sum - 7 * quotient, weekday = remainder + 1
    always_comb begin
        w_qa = WSUM_W'(r4_pa >> RECIP_SH);
        w_qb = WSUM_W'(r4_pb >> RECIP_SH);
        w_ra = r4_wa - ((w_qa << 3) - w_qa);
        w_rb = r4_wb - ((w_qb << 3) - w_qb);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s5) begin
            r5_diff   <= r4_diff[DIFF_W-1:0];
            r5_wa     <= w_ra[WDAY_W-1:0] + WDAY_W'(1);
            r5_wb     <= w_rb[WDAY_W-1:0] + WDAY_W'(1);
            r5_before <= (r4_diff > 0);
            r5_after  <= r4_diff[DNUM_W];
            r5_eq     <= r4_eq;
        end
    end

    assign o_diff   = r5_diff;
    assign o_wday_a = r5_wa;
    assign o_wday_b = r5_wb;
    assign o_before = r5_before;
    assign o_after  = r5_after;
    assign o_eq     = r5_eq;

endmodule
